// ----- rtl/core/nclc_pkg.sv -----
// ----------------------------------------------------------------------------
// nclc_pkg
// Shared types and codes of the command line checker: decoded byte entry,
// result status codes, number parser phases and the hex digit lookup.
// ----------------------------------------------------------------------------
package nclc_pkg;

   // result status codes
   localparam logic [2:0] STATUS_NEW      = 3'd0;
   localparam logic [2:0] STATUS_REPEAT   = 3'd1;
   localparam logic [2:0] STATUS_SHORT    = 3'd2;
   localparam logic [2:0] STATUS_BADSUM   = 3'd3;
   localparam logic [2:0] STATUS_NOCOMMA  = 3'd4;
   localparam logic [2:0] STATUS_OVERFLOW = 3'd5;

   // sequence number parser phases
   localparam logic [1:0] PHASE_SKIP = 2'd0;
   localparam logic [1:0] PHASE_NUM  = 2'd1;
   localparam logic [1:0] PHASE_DONE = 2'd2;

   // character codes
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_COMMA   = 8'h2C;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_VTAB    = 8'h0B;
   localparam logic [7:0] CHAR_FFEED   = 8'h0C;
   localparam logic [7:0] CHAR_CR      = 8'h0D;

   // request queue depth between front and back
   localparam int QUEUE_DEPTH = 2;

   // one classified request byte
   typedef struct packed {
      logic [7:0] data;
      logic       is_newline;
      logic       is_nul;
      logic       is_comma;
      logic       is_space;
      logic       is_sign;
      logic       is_minus;
      logic       is_digit;
      logic [3:0] digit;
   } entry_type;

   // nibble to uppercase ASCII hex character
   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] c;
      if (nib < 4'd10) begin
         c = CHAR_ZERO + {4'd0, nib};
      end else begin
         c = 8'h37 + {4'd0, nib};
      end
      return c;
   endfunction

endpackage

// ----- rtl/core/nclc_front.sv -----
// ----------------------------------------------------------------------------
// nclc_front
// Classifies each request byte into the flags the line engine needs.
// ----------------------------------------------------------------------------
module nclc_front
   import nclc_pkg::*;
(
   input  logic [7:0] rx_byte,
   output entry_type  entry
);

   always_comb begin
      entry.data       = rx_byte;
      entry.is_newline = (rx_byte == CHAR_NEWLINE);
      entry.is_nul     = (rx_byte == 8'h00);
      entry.is_comma   = (rx_byte == CHAR_COMMA);
      entry.is_space   = (rx_byte == CHAR_SPACE) || (rx_byte == CHAR_TAB) ||
                         (rx_byte == CHAR_VTAB)  || (rx_byte == CHAR_FFEED) ||
                         (rx_byte == CHAR_CR);
      entry.is_sign    = (rx_byte == CHAR_PLUS) || (rx_byte == CHAR_MINUS);
      entry.is_minus   = (rx_byte == CHAR_MINUS);
      entry.is_digit   = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
      entry.digit      = 4'(rx_byte - CHAR_ZERO);
   end

endmodule

// ----- rtl/core/nclc_queue.sv -----
// ----------------------------------------------------------------------------
// nclc_queue
// Short FIFO of classified bytes between the front and the line engine.
// ----------------------------------------------------------------------------
module nclc_queue
   import nclc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   output logic      head_valid,
   output entry_type head_entry,
   input  logic      pop
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int NW = $clog2(QUEUE_DEPTH + 1);

   entry_type       slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]   count_ff, count_in;

   assign full       = (count_ff == NW'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : PW'(wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : PW'(rd_ptr_ff + 1'b1);
      end
      if (push && !pop) begin
         count_in = NW'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = NW'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- rtl/core/nclc_back.sv -----
// ----------------------------------------------------------------------------
// nclc_back
// Line engine: tracks line state per byte, checks the line at newline or
// overflow and holds the result in the output register.
// ----------------------------------------------------------------------------
module nclc_back
   import nclc_pkg::*;
#(
   parameter int LINE_LIMIT = 256
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  entry_type          head_entry,
   output logic               head_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_status,
   output logic signed [31:0] rsp_sequence_res,
   output logic [7:0]         rsp_payload_start,
   output logic [7:0]         rsp_payload_length
);

   localparam int CW = $clog2(LINE_LIMIT + 1);

   logic [CW-1:0] stored_ff, stored_in;
   logic [CW-1:0] text_len_ff, text_len_in;
   logic          nul_seen_ff, nul_seen_in;
   logic [7:0]    xor_ff, xor_in;
   logic [7:0]    tail0_ff, tail0_in;
   logic [7:0]    tail1_ff, tail1_in;
   logic [7:0]    tail2_ff, tail2_in;
   logic [CW-1:0] comma_idx_ff, comma_idx_in;
   logic          comma_seen_ff, comma_seen_in;
   logic [1:0]    phase_ff, phase_in;
   logic          negative_ff, negative_in;
   logic [31:0]   value_ff, value_in;
   logic [31:0]   prev_seq_ff, prev_seq_in;

   logic          rsp_valid_ff;
   logic [2:0]    rsp_status_ff;
   logic [31:0]   rsp_seq_ff;
   logic [7:0]    rsp_start_ff;
   logic [7:0]    rsp_len_ff;

   logic          overflow;
   logic          gives_result;
   logic          out_free;
   logic [7:0]    body_xor;
   logic [CW-1:0] body_len;
   logic [CW-1:0] start_full;
   logic [CW-1:0] len_full;
   logic [31:0]   seq_val;
   logic [31:0]   value_x10;
   logic [2:0]    res_status;
   logic [31:0]   res_seq;
   logic [7:0]    res_start;
   logic [7:0]    res_len;

   assign overflow     = (stored_ff >= CW'(LINE_LIMIT));
   assign gives_result = overflow || head_entry.is_newline;
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign head_pop     = head_valid && (!gives_result || out_free);

   // line check
   assign body_xor   = xor_ff ^ tail0_ff ^ tail1_ff ^ tail2_ff;
   assign body_len   = CW'(text_len_ff - CW'(3));
   assign start_full = CW'(comma_idx_ff + 1'b1);
   assign len_full   = CW'(body_len - start_full);
   assign seq_val    = negative_ff ? (32'd0 - value_ff) : value_ff;
   assign value_x10  = {value_ff[28:0], 3'b000} + {value_ff[30:0], 1'b0};

   always_comb begin
      res_status = STATUS_NEW;
      res_seq    = '0;
      res_start  = '0;
      res_len    = '0;
      if (overflow) begin
         res_status = STATUS_OVERFLOW;
      end else if (text_len_ff < CW'(4)) begin
         res_status = STATUS_SHORT;
      end else if ((tail1_ff != hex_char(body_xor[7:4])) ||
                   (tail2_ff != hex_char(body_xor[3:0]))) begin
         res_status = STATUS_BADSUM;
      end else if (!comma_seen_ff || (comma_idx_ff >= body_len)) begin
         res_status = STATUS_NOCOMMA;
      end else begin
         res_seq    = seq_val;
         res_start  = start_full[7:0];
         res_len    = len_full[7:0];
         res_status = (seq_val != prev_seq_ff) ? STATUS_NEW : STATUS_REPEAT;
      end
   end

   // line state update
   always_comb begin
      stored_in     = stored_ff;
      text_len_in   = text_len_ff;
      nul_seen_in   = nul_seen_ff;
      xor_in        = xor_ff;
      tail0_in      = tail0_ff;
      tail1_in      = tail1_ff;
      tail2_in      = tail2_ff;
      comma_idx_in  = comma_idx_ff;
      comma_seen_in = comma_seen_ff;
      phase_in      = phase_ff;
      negative_in   = negative_ff;
      value_in      = value_ff;
      prev_seq_in   = prev_seq_ff;
      if (head_pop) begin
         if (gives_result) begin
            stored_in     = '0;
            text_len_in   = '0;
            nul_seen_in   = 1'b0;
            xor_in        = '0;
            tail0_in      = '0;
            tail1_in      = '0;
            tail2_in      = '0;
            comma_idx_in  = '0;
            comma_seen_in = 1'b0;
            phase_in      = PHASE_SKIP;
            negative_in   = 1'b0;
            value_in      = '0;
            if (res_status == STATUS_NEW) begin
               prev_seq_in = seq_val;
            end
         end else begin
            stored_in = CW'(stored_ff + 1'b1);
            if (!nul_seen_ff) begin
               if (head_entry.is_nul) begin
                  nul_seen_in = 1'b1;
               end else begin
                  if (!comma_seen_ff) begin
                     if (head_entry.is_comma) begin
                        comma_seen_in = 1'b1;
                        comma_idx_in  = text_len_ff;
                     end else begin
                        case (phase_ff)
                           PHASE_SKIP: begin
                              if (head_entry.is_space) begin
                                 phase_in = PHASE_SKIP;
                              end else if (head_entry.is_sign) begin
                                 negative_in = head_entry.is_minus;
                                 phase_in    = PHASE_NUM;
                              end else if (head_entry.is_digit) begin
                                 value_in = {28'd0, head_entry.digit};
                                 phase_in = PHASE_NUM;
                              end else begin
                                 phase_in = PHASE_DONE;
                              end
                           end
                           PHASE_NUM: begin
                              if (head_entry.is_digit) begin
                                 value_in = value_x10 + {28'd0, head_entry.digit};
                              end else begin
                                 phase_in = PHASE_DONE;
                              end
                           end
                           default: begin
                              phase_in = phase_ff;
                           end
                        endcase
                     end
                  end
                  xor_in      = xor_ff ^ head_entry.data;
                  tail0_in    = tail1_ff;
                  tail1_in    = tail2_ff;
                  tail2_in    = head_entry.data;
                  text_len_in = CW'(text_len_ff + 1'b1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stored_ff     <= '0;
         text_len_ff   <= '0;
         nul_seen_ff   <= 1'b0;
         xor_ff        <= '0;
         tail0_ff      <= '0;
         tail1_ff      <= '0;
         tail2_ff      <= '0;
         comma_idx_ff  <= '0;
         comma_seen_ff <= 1'b0;
         phase_ff      <= PHASE_SKIP;
         negative_ff   <= 1'b0;
         value_ff      <= '0;
         prev_seq_ff   <= '1;
      end else begin
         stored_ff     <= stored_in;
         text_len_ff   <= text_len_in;
         nul_seen_ff   <= nul_seen_in;
         xor_ff        <= xor_in;
         tail0_ff      <= tail0_in;
         tail1_ff      <= tail1_in;
         tail2_ff      <= tail2_in;
         comma_idx_ff  <= comma_idx_in;
         comma_seen_ff <= comma_seen_in;
         phase_ff      <= phase_in;
         negative_ff   <= negative_in;
         value_ff      <= value_in;
         prev_seq_ff   <= prev_seq_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (head_pop && gives_result) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (head_pop && gives_result) begin
         rsp_status_ff <= res_status;
         rsp_seq_ff    <= res_seq;
         rsp_start_ff  <= res_start;
         rsp_len_ff    <= res_len;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_sequence_res   = rsp_seq_ff;
   assign rsp_payload_start  = rsp_start_ff;
   assign rsp_payload_length = rsp_len_ff;

endmodule

// ----- rtl/core/nmea_command_line_checker.sv -----
// ----------------------------------------------------------------------------
// nmea_command_line_checker
// Assembles newline-terminated command lines from received bytes and checks
// length, XOR checksum suffix, comma and sequence number of each line.
// ----------------------------------------------------------------------------
//
//   channel | dir | handshake         | payload
//   --------+-----+-------------------+-------------------------------------
//   req     | in  | req_valid/stall   | rx_byte
//   rsp     | out | rsp_valid/stall   | status, sequence_res, payload_start,
//           |     |                   | payload_length
//
// One request byte per cycle sustained unless a stalled result fills the queue;
// the per-byte line update in the back end is the step that sets that rate.
// A newline (or overflowing byte) is written to the queue at the edge that
// takes it and to the output register, which raises rsp_valid, at the edge
// it leaves the queue.
// Synchronous active-high reset clears line state, queue and output valid;
// the previous sequence resets to minus one.
// A stalled result holds the back end only when its next request would also
// give a result; ordinary bytes keep flowing, and req_stall rises only when
// the two-entry queue is full.
//
module nmea_command_line_checker
   import nclc_pkg::*;
#(
   parameter int LINE_LIMIT = 256
)
(
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_rx_byte,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_status,
   output logic signed [31:0] rsp_sequence_res,
   output logic [7:0]         rsp_payload_start,
   output logic [7:0]         rsp_payload_length
);

   entry_type req_entry;
   entry_type head_entry;
   logic      queue_full;
   logic      head_valid;
   logic      head_pop;

   // front: classify the incoming byte
   nclc_front u_front (
      .rx_byte (req_rx_byte),
      .entry   (req_entry)
   );

   // queue decouples request acceptance from the line engine
   assign req_stall = queue_full;

   nclc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_valid && !queue_full),
      .push_entry (req_entry),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (head_pop)
   );

   // back: line state, checks and result register
   nclc_back #(
      .LINE_LIMIT (LINE_LIMIT)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .head_valid         (head_valid),
      .head_entry         (head_entry),
      .head_pop           (head_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_sequence_res   (rsp_sequence_res),
      .rsp_payload_start  (rsp_payload_start),
      .rsp_payload_length (rsp_payload_length)
   );

endmodule

// ----- rtl/core/nclc_checker.sv -----
// ----------------------------------------------------------------------------
// nclc_checker
// Port-level checks of the command line checker, bound to the top level.
// ----------------------------------------------------------------------------
module nclc_checker
   import nclc_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic [7:0]         req_rx_byte,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [2:0]         rsp_status,
   input logic signed [31:0] rsp_sequence_res,
   input logic [7:0]         rsp_payload_start,
   input logic [7:0]         rsp_payload_length
);

   // nothing is shown right after reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // status codes stay within the defined set
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= STATUS_OVERFLOW))
      else $error("undefined status code");

   // rejected lines carry zero fields
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_SHORT || rsp_status == STATUS_BADSUM ||
                     rsp_status == STATUS_NOCOMMA || rsp_status == STATUS_OVERFLOW))
      |-> (rsp_sequence_res == 32'sd0 && rsp_payload_start == 8'd0 &&
           rsp_payload_length == 8'd0))
      else $error("rejected line with non-zero fields");

   // a stalled result is held
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_status) &&
                                    $stable(rsp_sequence_res)))
      else $error("stalled result changed");

   // a stalled request is held by the sender
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_stall) |=> (req_valid && $stable(req_rx_byte)))
      else $error("stalled request changed");

endmodule

bind nmea_command_line_checker nclc_checker u_nclc_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .req_rx_byte        (req_rx_byte),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_status         (rsp_status),
   .rsp_sequence_res   (rsp_sequence_res),
   .rsp_payload_start  (rsp_payload_start),
   .rsp_payload_length (rsp_payload_length)
);

// ----- dv/nclc_tb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nclc_tb_pkg
// Line scoreboard for the command line checker: follows each accepted
// request byte, works out the verdict of every finished or overflowed line
// and checks the results of the block against those verdicts, oldest first.
// ----------------------------------------------------------------------------
package nclc_tb_pkg;
   import nclc_pkg::*;

   localparam int TB_LINE_LIMIT = 256;

   function automatic logic [7:0] ascii_hex(input logic [3:0] nib);
      string digits;
      digits = "0123456789ABCDEF";
      return digits[nib];
   endfunction

   class command_line_scoreboard;
      typedef struct packed {
         logic [2:0]         status;
         logic signed [31:0] sequence_res;
         logic [7:0]         payload_start;
         logic [7:0]         payload_length;
      } line_verdict_type;

      line_verdict_type expected_verdicts[$];
      int               errors;

      // state of the line being assembled
      int unsigned stored_bytes;
      int unsigned text_chars;
      bit          nul_seen;
      logic [7:0]  text_xor;
      logic [7:0]  last_three[3];
      int unsigned comma_pos;
      bit          comma_seen;
      logic [1:0]  phase;
      bit          minus;
      logic [31:0] number;
      // survives from line to line
      logic [31:0] accepted_sequence;

      function new();
         errors = 0;
         accepted_sequence = '1;
         restart_line();
      endfunction

      function void restart_line();
         stored_bytes = 0;
         text_chars = 0;
         nul_seen = 1'b0;
         text_xor = '0;
         last_three[0] = '0;
         last_three[1] = '0;
         last_three[2] = '0;
         comma_pos = 0;
         comma_seen = 1'b0;
         phase = PHASE_SKIP;
         minus = 1'b0;
         number = '0;
      endfunction

      // one accepted request byte
      function void note_request(input logic [7:0] c);
         line_verdict_type v;
         logic [7:0]       body_xor;
         int unsigned      body_chars;
         bit               digit;
         v = '0;
         if (stored_bytes >= TB_LINE_LIMIT) begin
            v.status = STATUS_OVERFLOW;
            expected_verdicts.push_back(v);
            restart_line();
         end else if (c == CHAR_NEWLINE) begin
            v.status = STATUS_SHORT;
            if (text_chars >= 4) begin
               body_xor = text_xor ^ last_three[0] ^ last_three[1] ^ last_three[2];
               body_chars = text_chars - 3;
               if (last_three[1] != ascii_hex(body_xor[7:4]) ||
                   last_three[2] != ascii_hex(body_xor[3:0])) begin
                  v.status = STATUS_BADSUM;
               end else if (!comma_seen || comma_pos >= body_chars) begin
                  v.status = STATUS_NOCOMMA;
               end else begin
                  v.sequence_res = minus ? (32'd0 - number) : number;
                  v.payload_start = 8'(comma_pos + 1);
                  v.payload_length = 8'(body_chars - comma_pos - 1);
                  if (v.sequence_res != accepted_sequence) begin
                     v.status = STATUS_NEW;
                     accepted_sequence = v.sequence_res;
                  end else begin
                     v.status = STATUS_REPEAT;
                  end
               end
            end
            expected_verdicts.push_back(v);
            restart_line();
         end else begin
            stored_bytes++;
            if (!nul_seen) begin
               if (c == 8'h00) begin
                  nul_seen = 1'b1;
               end else begin
                  if (!comma_seen) begin
                     digit = (c >= CHAR_ZERO && c <= CHAR_NINE);
                     if (c == CHAR_COMMA) begin
                        comma_seen = 1'b1;
                        comma_pos = text_chars;
                     end else begin
                        case (phase)
                           PHASE_SKIP: begin
                              if (!(c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_VTAB ||
                                    c == CHAR_FFEED || c == CHAR_CR)) begin
                                 if (c == CHAR_PLUS || c == CHAR_MINUS) begin
                                    minus = (c == CHAR_MINUS);
                                    phase = PHASE_NUM;
                                 end else if (digit) begin
                                    number = 32'(c - CHAR_ZERO);
                                    phase = PHASE_NUM;
                                 end else begin
                                    phase = PHASE_DONE;
                                 end
                              end
                           end
                           PHASE_NUM: begin
                              if (digit) begin
                                 number = number * 32'd10 + 32'(c - CHAR_ZERO);
                              end else begin
                                 phase = PHASE_DONE;
                              end
                           end
                           default: ;
                        endcase
                     end
                  end
                  text_xor ^= c;
                  last_three[0] = last_three[1];
                  last_three[1] = last_three[2];
                  last_three[2] = c;
                  text_chars++;
               end
            end
         end
      endfunction

      function void compare_field(input string name, input logic signed [32:0] want,
                                  input logic signed [32:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         end
      endfunction

      // one accepted result
      function void check_result(input logic [2:0] st, input logic signed [31:0] sq,
                                 input logic [7:0] ps, input logic [7:0] pl);
         line_verdict_type v;
         if (expected_verdicts.size() == 0) begin
            errors++;
            $display("%0t: result with nothing expected, status expected none, got %0d",
                     $time, st);
            return;
         end
         v = expected_verdicts.pop_front();
         compare_field("status", v.status, st);
         compare_field("sequence_res", v.sequence_res, sq);
         compare_field("payload_start", v.payload_start, ps);
         compare_field("payload_length", v.payload_length, pl);
      endfunction
   endclass

endpackage

// ----- dv/tb_nmea_command_line_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nmea_command_line_checker
// Feeds command lines to the checker byte by byte: a directed set of lines
// for each verdict and corner, a few lines at the store limit, then a
// random mix of good, corrupt, short, zero-cut and noise lines. Both
// handshakes idle and stall at random; a scoreboard predicts each verdict.
// ----------------------------------------------------------------------------
module tb_nmea_command_line_checker;
   import nclc_pkg::*;
   import nclc_tb_pkg::*;

   localparam logic [7:0] CHAR_STAR = 8'h2A;
   localparam logic [7:0] CHAR_NUL  = 8'h00;
   // directed and store-limit lines already send 924 requests
   localparam int RANDOM_REQUESTS   = 150;
   // slack after the last result to catch strays
   localparam int DRAIN_CYCLES      = 8;

   typedef enum int {SUFFIX_GOOD, SUFFIX_WRONG, SUFFIX_LOWER} suffix_kind_type;

   logic               clock;
   logic               reset       = 1'b1;
   logic               req_valid   = 1'b0;
   logic               req_stall;
   logic [7:0]         req_rx_byte = '0;
   logic               rsp_valid;
   logic               rsp_stall   = 1'b0;
   logic [2:0]         rsp_status;
   logic signed [31:0] rsp_sequence_res;
   logic [7:0]         rsp_payload_start;
   logic [7:0]         rsp_payload_length;

   command_line_scoreboard verdicts;

   // bytes of the line being built before it is sent
   logic [7:0]  line_buf[$];
   int unsigned requests_sent = 0;
   // calm stretches: no idling at all on that side
   bit          send_calm = 1'b0;
   bit          sink_calm = 1'b0;
   int          stall_left = 0;
   logic [7:0]  blank_chars[5] = '{CHAR_SPACE, CHAR_TAB, CHAR_VTAB, CHAR_FFEED, CHAR_CR};

   nmea_command_line_checker #(
      .LINE_LIMIT(TB_LINE_LIMIT)
   ) DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_sequence_res   (rsp_sequence_res),
      .rsp_payload_start  (rsp_payload_start),
      .rsp_payload_length (rsp_payload_length)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // mostly back to back, often a short pause, now and then a long one
   function automatic int pick_gap(input bit calm);
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Result side. Stall and valid are sampled as they stood before the edge,
   // so a result counts exactly when the handshake completes at this edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         verdicts.check_result(rsp_status, rsp_sequence_res, rsp_payload_start,
                               rsp_payload_length);
      end
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
         if ($urandom_range(0, 3) == 0) stall_left = pick_gap(sink_calm);
      end
      if ($urandom_range(0, 199) == 0) sink_calm = !sink_calm;
   end

   // One request. Valid is only dropped when a pause is wanted, so a
   // back-to-back request never sees valid lowered and raised in one step.
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = pick_gap(send_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      verdicts.note_request(b);
      requests_sent++;
      if ($urandom_range(0, 149) == 0) send_calm = !send_calm;
   endtask

   task automatic send_line(input bit with_newline);
      foreach (line_buf[i]) send_byte(line_buf[i]);
      if (with_newline) send_byte(CHAR_NEWLINE);
      line_buf.delete();
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
   endtask

   // random characters, never a newline; zero bytes only when asked for
   task automatic add_noise(input int count, input bit with_nul);
      logic [7:0] c;
      repeat (count) begin
         do c = 8'($urandom_range(0, 255));
         while (c == CHAR_NEWLINE || (c == CHAR_NUL && !with_nul));
         line_buf.push_back(c);
      end
   endtask

   // Separator then the XOR of everything so far as two hex characters.
   // A wrong suffix flips some bits of the low digit; the lower-case form
   // only differs from a good one where a digit is a letter.
   task automatic add_suffix(input logic [7:0] sep, input suffix_kind_type kind);
      logic [7:0] sum;
      logic [7:0] hi;
      logic [7:0] lo;
      sum = '0;
      foreach (line_buf[i]) sum ^= line_buf[i];
      hi = ascii_hex(sum[7:4]);
      lo = ascii_hex(sum[3:0]);
      if (kind == SUFFIX_WRONG) begin
         lo = ascii_hex(sum[3:0] ^ 4'($urandom_range(1, 15)));
      end else if (kind == SUFFIX_LOWER) begin
         hi = hi | 8'h20;
         lo = lo | 8'h20;
      end
      line_buf.push_back(sep);
      line_buf.push_back(hi);
      line_buf.push_back(lo);
   endtask

   // Text in front of the first comma: optional blanks and sign, then a
   // small number (repeats likely), a full 32-bit one, one long enough to
   // wrap, no digits at all, or digits cut short by a letter.
   function automatic string pick_sequence();
      string s;
      int    kind;
      s = "";
      if ($urandom_range(0, 4) == 0) begin
         repeat ($urandom_range(1, 3)) s = $sformatf("%s%c", s, blank_chars[$urandom_range(0, 4)]);
      end
      case ($urandom_range(0, 9))
         0: s = {s, "-"};
         1: s = {s, "+"};
         default: ;
      endcase
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
         s = $sformatf("%s%0d", s, $urandom_range(0, 4));
      end else if (kind < 7) begin
         s = $sformatf("%s%0d", s, $urandom());
      end else if (kind == 7) begin
         s = $sformatf("%s%0d%0d", s, $urandom(), $urandom());
      end else if (kind == 8) begin
         s = {s, "X"};
      end else begin
         s = $sformatf("%s%0dx%0d", s, $urandom_range(0, 99), $urandom_range(0, 9));
      end
      return s;
   endfunction

   initial begin
      int unsigned     random_end;
      int              pick;
      suffix_kind_type sfx;

      verdicts = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // ---- directed lines ----
      // previous sequence comes out of reset as minus one: a repeat
      add_text("-1,A");
      add_suffix(CHAR_STAR, SUFFIX_GOOD);
      send_line(1'b1);
      add_text("12,HELLO");
      add_suffix(CHAR_STAR, SUFFIX_GOOD);
      send_line(1'b1);
      add_text("12,AGAIN");
      add_suffix(CHAR_STAR, SUFFIX_GOOD);
      send_line(1'b1);
      // every blank character ahead of a signed number
      foreach (blank_chars[i]) line_buf.push_back(blank_chars[i]);
      add_text("-42,X");
      add_suffix(CHAR_STAR, SUFFIX_GOOD);
      send_line(1'b1);
      // empty command text
      add_text("+7,");
      add_suffix(CHAR_STAR, SUFFIX_GOOD);
      send_line(1'b1);
      // no digits reads as zero
      add_text("abc,Z");
      add_suffix(CHAR_STAR, SUFFIX_GOOD);
      send_line(1'b1);
      // beyond 32 bits: wraps round to one
      add_text("4294967297,Q");
      add_suffix(CHAR_STAR, SUFFIX_GOOD);
      send_line(1'b1);
      // shortest line that can pass: four characters
      add_text(",");
      add_suffix(CHAR_STAR, SUFFIX_GOOD);
      send_line(1'b1);
      // too short: bare newline, then three characters
      send_line(1'b1);
      add_text("ABC");
      send_line(1'b1);
      add_text("5,DATA");
      add_suffix(CHAR_STAR, SUFFIX_WRONG);
      send_line(1'b1);
      // body XOR is 5B, so lower case hex must be refused
      add_text("1,F");
      add_suffix(CHAR_STAR, SUFFIX_LOWER);
      send_line(1'b1);
      add_text("5DATA");
      add_suffix(CHAR_STAR, SUFFIX_GOOD);
      send_line(1'b1);
      // the only comma sits in the suffix
      add_text("5DATA");
      add_suffix(CHAR_COMMA, SUFFIX_GOOD);
      send_line(1'b1);
      // a zero byte ends the text; what follows is stored but ignored
      add_text("8,AB");
      add_suffix(CHAR_STAR, SUFFIX_GOOD);
      line_buf.push_back(CHAR_NUL);
      add_text("XYZ");
      send_line(1'b1);
      // zero byte mid-body cuts the suffix off
      add_text("9,AB");
      line_buf.push_back(CHAR_NUL);
      add_text("CD");
      add_suffix(CHAR_STAR, SUFFIX_GOOD);
      send_line(1'b1);
      // top-bit characters in the command text
      add_text("6,");
      line_buf.push_back(8'hFF);
      line_buf.push_back(8'h80);
      add_suffix(CHAR_STAR, SUFFIX_GOOD);
      send_line(1'b1);

      // ---- store limit ----
      // longest line that still fits: 255 characters then the newline
      add_text("3,");
      add_noise(TB_LINE_LIMIT - 6, 1'b0);
      add_suffix(CHAR_STAR, SUFFIX_GOOD);
      send_line(1'b1);
      // store full, the newline itself overflows
      add_noise(TB_LINE_LIMIT, 1'b1);
      send_line(1'b1);
      // store full, an ordinary byte overflows and is dropped
      add_noise(TB_LINE_LIMIT, 1'b1);
      add_text("A");
      send_line(1'b0);

      // ---- random lines, mostly well formed ----
      random_end = requests_sent + RANDOM_REQUESTS;
      while (requests_sent < random_end) begin
         pick = $urandom_range(0, 99);
         if (pick < 68) begin
            add_text(pick_sequence());
            line_buf.push_back(CHAR_COMMA);
            add_noise($urandom_range(0, 12), 1'b0);
            case ($urandom_range(0, 9))
               7, 8: sfx = SUFFIX_WRONG;
               9:    sfx = SUFFIX_LOWER;
               default: sfx = SUFFIX_GOOD;
            endcase
            add_suffix(CHAR_STAR, sfx);
            if ($urandom_range(0, 9) == 0) begin
               line_buf.push_back(CHAR_NUL);
               add_noise($urandom_range(0, 4), 1'b1);
            end
            send_line(1'b1);
         end else if (pick < 76) begin
            // no comma in the body; sometimes one in the suffix
            add_text(pick_sequence());
            add_text("GO");
            add_suffix(($urandom_range(0, 1) == 0) ? CHAR_STAR : CHAR_COMMA, SUFFIX_GOOD);
            send_line(1'b1);
         end else if (pick < 84) begin
            add_noise($urandom_range(0, 3), 1'b1);
            send_line(1'b1);
         end else if (pick < 91) begin
            // good line with a zero byte dropped in anywhere
            add_text(pick_sequence());
            line_buf.push_back(CHAR_COMMA);
            add_noise($urandom_range(0, 8), 1'b0);
            add_suffix(CHAR_STAR, SUFFIX_GOOD);
            line_buf.insert($urandom_range(0, line_buf.size()), CHAR_NUL);
            send_line(1'b1);
         end else begin
            // raw noise, newlines included; may run on into the next line
            repeat ($urandom_range(1, 16)) line_buf.push_back(8'($urandom_range(0, 255)));
            send_line(1'($urandom_range(0, 1)));
         end
      end
      req_valid <= 1'b0;

      while (verdicts.expected_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (verdicts.errors == 0) begin
         $display("tb_nmea_command_line_checker: done, clean");
      end else begin
         $display("tb_nmea_command_line_checker: done, errors");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #2000000;
      $display("tb_nmea_command_line_checker: done, errors");
      $finish;
   end

endmodule

// ----- nmea_command_line_checker.f -----
rtl/core/nclc_pkg.sv
rtl/core/nclc_front.sv
rtl/core/nclc_queue.sv
rtl/core/nclc_back.sv
rtl/core/nmea_command_line_checker.sv
rtl/core/nclc_checker.sv
dv/nclc_tb_pkg.sv
dv/tb_nmea_command_line_checker.sv
